FILE: design/sgm_pkg.sv
// Shared types and constants for the sustained growth monitor.
package sgm_pkg;

   localparam int unsigned DATA_W   = 48;
   localparam int unsigned FILL_W   = 6;
   localparam int unsigned THR_W    = 4;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GROWTH_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GROWTH_BYTES = 2'd1;

   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 4'd3;
   localparam logic [DATA_W-1:0] MIN_GROWTH_RESET = 48'd4096;
   localparam logic [FILL_W-1:0] THRESHOLD_FLOOR = 6'd2;

   typedef struct packed {
      logic              valid;
      logic              seen;
      logic [FILL_W-1:0] fill;
      logic [DATA_W-1:0] handle;
      logic [DATA_W-1:0] stamp;
      logic [DATA_W-1:0] last_alert;
   } sgm_entry_type;

endpackage

FILE: design/sgm_cell.sv
// One table entry of the rotating chain: key, sample line and flags, with local key match.
module sgm_cell
   import sgm_pkg::*;
#(
   parameter int unsigned RING_DEPTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              shift,
   input  sgm_entry_type                     ent_in,
   input  logic [RING_DEPTH-1:0][DATA_W-1:0] ring_in,
   input  logic [DATA_W-1:0]                 key_handle,
   input  logic [DATA_W-1:0]                 key_stamp,
   output sgm_entry_type                     ent_out,
   output logic [RING_DEPTH-1:0][DATA_W-1:0] ring_out,
   output logic                              hit,
   output logic                              free
);

   sgm_entry_type                     ent_ff;
   logic [RING_DEPTH-1:0][DATA_W-1:0] ring_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         ent_ff  <= ent_in;
         ring_ff <= ring_in;
      end
      if (reset) begin
         ent_ff.valid <= 1'b0;
         ent_ff.seen  <= 1'b0;
      end
   end

   assign ent_out  = ent_ff;
   assign ring_out = ring_ff;
   assign hit  = ent_ff.valid && (ent_ff.handle == key_handle) && (ent_ff.stamp == key_stamp);
   assign free = !ent_ff.valid;

endmodule

FILE: design/sustained_growth_monitor_unit.sv
// Top level: growth monitor over a rotating chain of entry cells.
//
//  channel | ports                                   | dir | handshake
//  req     | req_kind/handle/creation_stamp/position | in  | req_valid/req_ready
//  rsp     | rsp_alert/growing/growth_bytes/...      | out | rsp_valid/rsp_ready
//  csr     | csr_index/csr_wdata                     | in  | csr_we
//
// The entry ring rotates one cell a cycle while shift is high; the head entry is under work.
// Sample word: look-up, then up to MAX_ENTRIES - 1 rotations to bring the entry to the head,
// then the check states CHK1 and CHK2; a new key goes to a free cell or is dropped if full.
// Round-end word: one full rotation of the ring.
// Reset clears valid bits and counters. A new word is taken while a result waits;
// the final step of a word stalls until the output register is free.
module sustained_growth_monitor_unit
   import sgm_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 64,
   parameter int unsigned RING_DEPTH  = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [DATA_W-1:0]    req_handle,
   input  logic [DATA_W-1:0]    req_creation_stamp,
   input  logic [DATA_W-1:0]    req_position,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_alert,
   output logic                 rsp_growing,
   output logic [DATA_W-1:0]    rsp_growth_bytes,
   output logic                 rsp_entry_dropped,
   output logic [COUNT_W-1:0]   rsp_entries_in_use,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned POS_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned RING_W = $clog2(RING_DEPTH);
   localparam logic [FILL_W-1:0] RING_FILL = FILL_W'(RING_DEPTH);
   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_ENTRIES);
   localparam logic [POS_W-1:0]  SWEEP_LAST = POS_W'(MAX_ENTRIES - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_LOOK, S_SEEK_HIT, S_CHK1, S_CHK2, S_SEEK_FREE, S_SWEEP
   } state_type;

   state_type            state_ff;
   logic [DATA_W-1:0]    handle_ff, stamp_ff, pos_ff;
   logic [THR_W-1:0]     growth_ff;
   logic [DATA_W-1:0]    min_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [POS_W-1:0]     sweep_ff;
   logic [RING_DEPTH-1:0] ok_ff;
   logic [DATA_W-1:0]    diff_ff;
   logic [FILL_W-1:0]    fill_new_ff;
   logic                 rsp_valid_ff, rsp_alert_ff, rsp_growing_ff, rsp_dropped_ff;
   logic [DATA_W-1:0]    rsp_growth_ff;
   logic [CNT_W-1:0]     rsp_count_ff;

   sgm_entry_type                     ent_chain  [MAX_ENTRIES];
   logic [RING_DEPTH-1:0][DATA_W-1:0] ring_chain [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]            hit_vec, free_vec;

   sgm_entry_type                     head, head_in;
   logic [RING_DEPTH-1:0][DATA_W-1:0] head_ring, ring_new, ring_in;
   logic                              shift, out_free, any_hit;
   logic [FILL_W-1:0]                 thr, fill_new;
   logic [RING_DEPTH-1:0]             ok_in, thr_mask;
   logic                              grow, alert;

   assign head      = ent_chain[MAX_ENTRIES-1];
   assign head_ring = ring_chain[MAX_ENTRIES-1];
   assign any_hit   = |hit_vec;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      sgm_cell #(.RING_DEPTH(RING_DEPTH)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (shift),
         .ent_in     ((i == 0) ? head_in : ent_chain[(i == 0) ? 0 : i-1]),
         .ring_in    ((i == 0) ? ring_in : ring_chain[(i == 0) ? 0 : i-1]),
         .key_handle (handle_ff),
         .key_stamp  (stamp_ff),
         .ent_out    (ent_chain[i]),
         .ring_out   (ring_chain[i]),
         .hit        (hit_vec[i]),
         .free       (free_vec[i])
      );
   end

   always_comb begin
      ring_new[0] = pos_ff;
      for (int j = 1; j < RING_DEPTH; j++) ring_new[j] = head_ring[j-1];
      if ({2'b00, growth_ff} < THRESHOLD_FLOOR) thr = THRESHOLD_FLOOR;
      else if ({2'b00, growth_ff} > RING_FILL) thr = RING_FILL;
      else thr = {2'b00, growth_ff};
      fill_new = (head.fill >= RING_FILL) ? head.fill : head.fill + 6'd1;
      ok_in[0] = 1'b1;
      for (int j = 1; j < RING_DEPTH; j++) ok_in[j] = ring_new[j] < ring_new[j-1];
      for (int j = 0; j < RING_DEPTH; j++) thr_mask[j] = (FILL_W'(j) < thr);
      grow  = (fill_new_ff >= thr) && (&(ok_ff | ~thr_mask)) && (diff_ff >= min_ff);
      alert = grow && (pos_ff != head.last_alert);
   end

   always_comb begin
      head_in = head;
      ring_in = head_ring;
      shift   = 1'b0;
      case (state_ff)
         S_SEEK_HIT:  shift = !hit_vec[MAX_ENTRIES-1];
         S_CHK2: begin
            shift         = out_free;
            ring_in       = ring_new;
            head_in.fill  = fill_new_ff;
            head_in.seen  = 1'b1;
            if (alert) head_in.last_alert = pos_ff;
         end
         S_SEEK_FREE: begin
            shift = !free_vec[MAX_ENTRIES-1] || out_free;
            if (free_vec[MAX_ENTRIES-1]) begin
               ring_in            = ring_new;
               head_in.valid      = 1'b1;
               head_in.seen       = 1'b1;
               head_in.fill       = 6'd1;
               head_in.handle     = handle_ff;
               head_in.stamp      = stamp_ff;
               head_in.last_alert = '0;
            end
         end
         S_SWEEP: begin
            shift = (sweep_ff != SWEEP_LAST) || out_free;
            if (!head.seen) head_in.valid = 1'b0;
            head_in.seen = 1'b0;
         end
         default: shift = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (csr_we) begin
         case (csr_index)
            CSR_GROWTH_THRESHOLD: growth_ff <= csr_wdata[THR_W-1:0];
            CSR_MIN_GROWTH_BYTES: min_ff    <= csr_wdata;
            default: ;
         endcase
      end
      if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               handle_ff <= req_handle;
               stamp_ff  <= req_creation_stamp;
               pos_ff    <= req_position;
               sweep_ff  <= '0;
               state_ff  <= req_kind ? S_SWEEP : S_LOOK;
            end
         end
         S_LOOK: begin
            if (any_hit) state_ff <= S_SEEK_HIT;
            else if (count_ff < CNT_MAX) state_ff <= S_SEEK_FREE;
            else if (out_free) begin
               rsp_valid_ff   <= 1'b1;
               rsp_alert_ff   <= 1'b0;
               rsp_growing_ff <= 1'b0;
               rsp_growth_ff  <= '0;
               rsp_dropped_ff <= 1'b1;
               rsp_count_ff   <= count_ff;
               state_ff       <= S_IDLE;
            end
         end
         S_SEEK_HIT: if (hit_vec[MAX_ENTRIES-1]) state_ff <= S_CHK1;
         S_CHK1: begin
            ok_ff       <= ok_in;
            diff_ff     <= pos_ff - ring_new[RING_W'(thr - 6'd1)];
            fill_new_ff <= fill_new;
            state_ff    <= S_CHK2;
         end
         S_CHK2: begin
            if (out_free) begin
               rsp_valid_ff   <= 1'b1;
               rsp_alert_ff   <= alert;
               rsp_growing_ff <= grow;
               rsp_growth_ff  <= grow ? diff_ff : '0;
               rsp_dropped_ff <= 1'b0;
               rsp_count_ff   <= count_ff;
               state_ff       <= S_IDLE;
            end
         end
         S_SEEK_FREE: begin
            if (free_vec[MAX_ENTRIES-1] && out_free) begin
               count_ff       <= count_ff + 1'b1;
               rsp_valid_ff   <= 1'b1;
               rsp_alert_ff   <= 1'b0;
               rsp_growing_ff <= 1'b0;
               rsp_growth_ff  <= '0;
               rsp_dropped_ff <= 1'b0;
               rsp_count_ff   <= count_ff + 1'b1;
               state_ff       <= S_IDLE;
            end
         end
         S_SWEEP: begin
            if (shift) begin
               sweep_ff <= sweep_ff + 1'b1;
               if (head.valid && !head.seen) count_ff <= count_ff - 1'b1;
               if (sweep_ff == SWEEP_LAST) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_alert_ff   <= 1'b0;
                  rsp_growing_ff <= 1'b0;
                  rsp_growth_ff  <= '0;
                  rsp_dropped_ff <= 1'b0;
                  rsp_count_ff   <= (head.valid && !head.seen) ? count_ff - 1'b1 : count_ff;
                  state_ff       <= S_IDLE;
               end
            end
         end
         default: state_ff <= S_IDLE;
      endcase
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         growth_ff    <= THRESHOLD_RESET;
         min_ff       <= MIN_GROWTH_RESET;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_alert          = rsp_alert_ff;
   assign rsp_growing        = rsp_growing_ff;
   assign rsp_growth_bytes   = rsp_growth_ff;
   assign rsp_entry_dropped  = rsp_dropped_ff;
   assign rsp_entries_in_use = COUNT_W'(rsp_count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX) else $error("entry count above table size");
   a_alert_grow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_alert_ff |-> rsp_growing_ff) else $error("alert without growth");
   a_drop_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dropped_ff |-> !rsp_growing_ff && (rsp_count_ff == CNT_MAX))
      else $error("drop with growth or table not full");

endmodule
